@@ hw/rtl/tli_pkg.sv @@
// Package for the triangle Lambert intensity block.
// It holds the widths, the configuration register codes, the pipeline stage types and helpers.
// It has no dependencies. The interfaces, the top level and the checker import it.
package tli_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NORM_BITS   = 18;

    // Edge vectors, cross product terms, normal and light direction.
    localparam int AW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * AW;
    localparam int NW   = 2 * COORD_WIDTH + 3;
    localparam int DW   = COORD_WIDTH + 3;
    localparam int TW   = $clog2(NW + 1);
    // Scaled vectors, their products and sums.
    localparam int SW   = NORM_BITS + 1;
    localparam int MW   = 2 * SW;
    localparam int DOTW = 2 * NORM_BITS + 3;
    // Square root and division.
    localparam int RTW  = NORM_BITS + 1;
    localparam int QW   = 2 * RTW;
    localparam int RMW  = RTW + 2;
    localparam int DENW = 2 * RTW;
    localparam int REMW = DENW + 1;
    localparam int OUTW = FRAC_BITS + 1;

    localparam int SQ_PER    = 2;
    localparam int SQ_ST     = (RTW + SQ_PER - 1) / SQ_PER;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int DIV_PER   = 2;
    localparam int DIV_ST    = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
    // Front stages (7), root seed and root stages, product, divide seed and
    // divide stages, output register.
    localparam int NST       = SQ_ST + DIV_ST + 11;

    localparam logic [OUTW-1:0] ONE = OUTW'(1) << FRAC_BITS;

    localparam int CFG_IW = 2;
    typedef enum logic [CFG_IW-1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [QW-1:0]          vn;
        logic [QW-1:0]          vd;
        logic [RMW-1:0]         remn;
        logic [RMW-1:0]         remd;
        logic [RTW-1:0]         rootn;
        logic [RTW-1:0]         rootd;
        logic signed [DOTW-1:0] dot;
        logic                   degen;
    } t_sq_st;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [RTW-1:0] root;
    } t_sq_acc;

    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [DENW-1:0] den;
        logic            lsb;
        logic [OUTW-1:0] q;
        logic            sat;
        logic            zero;
        logic            degen;
    } t_dv_st;

    function automatic logic [TW-1:0] bitlen(input logic [NW-1:0] m);
        logic [TW-1:0] n;
        n = '0;
        for (int i = 0; i < NW; i++) begin
            if (m[i]) n = TW'(i + 1);
        end
        return n;
    endfunction

    // Brings a magnitude to NORM_BITS bits; a right shift truncates.
    function automatic logic [NORM_BITS-1:0] scale_mag(input logic [NW-1:0] m,
                                                      input logic [TW-1:0] top);
        logic [NW-1:0] t;
        if (top > TW'(NORM_BITS)) begin
            t = m >> (top - TW'(NORM_BITS));
        end else begin
            t = m << (TW'(NORM_BITS) - top);
        end
        return t[NORM_BITS-1:0];
    endfunction

    // One step of the restoring square root, two radicand bits per step.
    function automatic t_sq_acc sq_step(input logic [RMW-1:0] rem,
                                        input logic [RTW-1:0] root,
                                        input logic [1:0] pair);
        logic [RMW-1:0] r;
        logic [RMW-1:0] t;
        t_sq_acc        o;
        r = {rem[RMW-3:0], pair};
        t = {root, 2'b01};
        if (r >= t) begin
            o.rem  = r - t;
            o.root = {root[RTW-2:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {root[RTW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ hw/rtl/tli_in_if.sv @@
// Input channel of the triangle Lambert intensity block: one triangle per item.
// It depends on tli_pkg for the coordinate width.
interface tli_in_if import tli_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z;
    logic signed [COORD_WIDTH-1:0] v3_x, v3_y, v3_z;

    modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    v3_x, v3_y, v3_z, input ready);
    modport sink   (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    v3_x, v3_y, v3_z, output ready);
endinterface

@@ hw/rtl/tli_out_if.sv @@
// Result channel of the triangle Lambert intensity block: brightness and degenerate flag.
// It depends on tli_pkg for the brightness width.
interface tli_out_if import tli_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [OUTW-1:0] brightness;
    logic            degenerate;

    modport source (output valid, brightness, degenerate, input ready);
    modport sink   (input valid, brightness, degenerate, output ready);
endinterface

@@ hw/rtl/triangle_lambert_intensity.sv @@
// Top level of the triangle Lambert intensity block: a pipeline from the triangle to the brightness.
// It depends on tli_pkg, tli_in_if and tli_out_if.
//
// The block takes one triangle in every cycle unless the output stalls, and gives its flat-shading
// brightness. The result is the clamped cosine between the face normal and the direction from the
// centroid to the light, in Q1.16. The pipeline has 30 register stages, and the last one is the
// output register. Most of the length comes from two iterative units: the 19-step square roots
// of the two vector lengths take two steps per stage, and the 17-step division takes two quotient
// bits per stage. The whole pipeline holds while a finished result waits to be taken. The light
// position is read from its registers when a triangle is accepted. Write it only while no item
// is in flight.
module triangle_lambert_intensity import tli_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IW-1:0]      i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    tli_in_if.sink                 i_tri,
    tli_out_if.source              o_res
);

    logic signed [COORD_WIDTH-1:0] r_light [3];
    logic [NST-1:0]                r_vld;
    logic [NST-1:0]                n_vld;
    logic                          en;

    logic signed [COORD_WIDTH-1:0] w_p1 [3];
    logic signed [COORD_WIDTH-1:0] w_p2 [3];
    logic signed [COORD_WIDTH-1:0] w_p3 [3];

    logic signed [AW-1:0]   r_a  [3];
    logic signed [AW-1:0]   r_b  [3];
    logic signed [DW-1:0]   r_d1 [3];
    logic signed [AW-1:0]   n_a  [3];
    logic signed [AW-1:0]   n_b  [3];
    logic signed [DW-1:0]   n_d  [3];
    logic signed [PW-1:0]   r_p  [6];
    logic signed [DW-1:0]   r_d2 [3];
    logic signed [NW-1:0]   r_n  [3];
    logic signed [DW-1:0]   r_d3 [3];
    logic [NW-1:0]          r_mn [3];
    logic [NW-1:0]          r_md [3];
    logic                   r_sgn_n [3];
    logic                   r_sgn_d [3];
    logic [NW-1:0]          r_mn5 [3];
    logic [NW-1:0]          r_md5 [3];
    logic                   r_sgn_n5 [3];
    logic                   r_sgn_d5 [3];
    logic [TW-1:0]          r_topn;
    logic [TW-1:0]          r_topd;
    logic signed [SW-1:0]   r_sn [3];
    logic signed [SW-1:0]   r_sd [3];
    logic                   r_dg6;
    logic signed [MW-1:0]   r_nd [3];
    logic signed [MW-1:0]   r_nn [3];
    logic signed [MW-1:0]   r_dd [3];
    logic                   r_dg7;
    t_sq_st                 r_sq [SQ_ST+1];
    t_sq_st                 n_sq [SQ_ST+1];
    t_sq_st                 n_sq0;
    logic [DENW-1:0]        r_den;
    logic signed [DOTW-1:0] r_dot;
    logic                   r_dgd;
    t_dv_st                 r_dv [DIV_ST+1];
    t_dv_st                 n_dv [DIV_ST+1];
    logic [OUTW-1:0]        r_bright;
    logic                   r_degen;
    logic [OUTW-1:0]        n_bright;

    // The pipeline advances as a whole unless the output register is full and stalled.
    assign en          = !r_vld[NST-1] || o_res.ready;
    assign i_tri.ready = en;
    assign n_vld       = {r_vld[NST-2:0], i_tri.valid};

    assign w_p1[0] = i_tri.v1_x; assign w_p1[1] = i_tri.v1_y; assign w_p1[2] = i_tri.v1_z;
    assign w_p2[0] = i_tri.v2_x; assign w_p2[1] = i_tri.v2_y; assign w_p2[2] = i_tri.v2_z;
    assign w_p3[0] = i_tri.v3_x; assign w_p3[1] = i_tri.v3_y; assign w_p3[2] = i_tri.v3_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light[0] <= '0;
            r_light[1] <= '0;
            r_light[2] <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LIGHT_X: r_light[0] <= i_cfg_data;
                CFG_LIGHT_Y: r_light[1] <= i_cfg_data;
                CFG_LIGHT_Z: r_light[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    // Edge vectors and three times the centroid-to-light vector.
    always_comb begin
        logic signed [DW-1:0] lx;
        for (int k = 0; k < 3; k++) begin
            n_a[k] = AW'(w_p1[k]) - AW'(w_p2[k]);
            n_b[k] = AW'(w_p2[k]) - AW'(w_p3[k]);
            lx     = DW'(r_light[k]);
            n_d[k] = lx + (lx <<< 1) - (DW'(w_p1[k]) + DW'(w_p2[k]) + DW'(w_p3[k]));
        end
    end

    // Seed of the square root pipeline: dot product and squared lengths.
    always_comb begin
        logic signed [DOTW-1:0] snn;
        logic signed [DOTW-1:0] sdd;
        snn = DOTW'(r_nn[0]) + DOTW'(r_nn[1]) + DOTW'(r_nn[2]);
        sdd = DOTW'(r_dd[0]) + DOTW'(r_dd[1]) + DOTW'(r_dd[2]);
        n_sq0.vn    = snn[QW-1:0];
        n_sq0.vd    = sdd[QW-1:0];
        n_sq0.remn  = '0;
        n_sq0.remd  = '0;
        n_sq0.rootn = '0;
        n_sq0.rootd = '0;
        n_sq0.dot   = DOTW'(r_nd[0]) + DOTW'(r_nd[1]) + DOTW'(r_nd[2]);
        n_sq0.degen = r_dg7;
    end

    always_comb begin
        t_sq_st  cur;
        t_sq_acc an;
        t_sq_acc ad;
        int      k;
        n_sq[0] = n_sq0;
        for (int s = 0; s < SQ_ST; s++) begin
            cur = r_sq[s];
            for (int j = 0; j < SQ_PER; j++) begin
                k = s * SQ_PER + j;
                if (k < RTW) begin
                    an = sq_step(cur.remn, cur.rootn, cur.vn[QW-2-2*k +: 2]);
                    ad = sq_step(cur.remd, cur.rootd, cur.vd[QW-2-2*k +: 2]);
                    cur.remn  = an.rem;
                    cur.rootn = an.root;
                    cur.remd  = ad.rem;
                    cur.rootd = ad.root;
                end
            end
            n_sq[s+1] = cur;
        end
    end

    // Divide seed: saturation test, then the quotient bits below two.
    always_comb begin
        logic [DENW-1:0] dm;
        logic            pos;
        t_dv_st          cur;
        logic [REMW-1:0] r;
        int              k;
        dm  = r_dot[DOTW-2:0];
        pos = !r_dot[DOTW-1] && (r_dot != '0);
        n_dv[0].rem   = REMW'(dm >> 1);
        n_dv[0].den   = r_den;
        n_dv[0].lsb   = dm[0];
        n_dv[0].q     = '0;
        n_dv[0].sat   = {1'b0, dm} >= {r_den, 1'b0};
        n_dv[0].zero  = r_dgd || !pos;
        n_dv[0].degen = r_dgd;
        for (int s = 0; s < DIV_ST; s++) begin
            cur = r_dv[s];
            for (int j = 0; j < DIV_PER; j++) begin
                k = s * DIV_PER + j;
                if (k < DIV_STEPS) begin
                    // Only the first step brings in a numerator bit; the rest are zero.
                    r = {cur.rem[REMW-2:0], (k == 0) ? cur.lsb : 1'b0};
                    if (r >= {1'b0, cur.den}) begin
                        cur.rem = r - {1'b0, cur.den};
                        cur.q   = {cur.q[OUTW-2:0], 1'b1};
                    end else begin
                        cur.rem = r;
                        cur.q   = {cur.q[OUTW-2:0], 1'b0};
                    end
                end
            end
            n_dv[s+1] = cur;
        end
    end

    always_comb begin
        t_dv_st f;
        f = r_dv[DIV_ST];
        if (f.zero) begin
            n_bright = '0;
        end else if (f.sat || f.q > ONE) begin
            n_bright = ONE;
        end else begin
            n_bright = f.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k]  <= n_a[k];
                r_b[k]  <= n_b[k];
                r_d1[k] <= n_d[k];
                r_d2[k] <= r_d1[k];
            end
            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_a[2] * r_b[1];
            r_p[2] <= r_a[2] * r_b[0];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_a[1] * r_b[0];
            for (int k = 0; k < 3; k++) begin
                r_n[k]  <= NW'(r_p[2*k]) - NW'(r_p[2*k+1]);
                r_d3[k] <= r_d2[k];
                // Sign and magnitude of both vectors.
                r_sgn_n[k] <= r_n[k][NW-1];
                r_mn[k]    <= r_n[k][NW-1] ? NW'(-r_n[k]) : NW'(r_n[k]);
                r_sgn_d[k] <= r_d3[k][DW-1];
                r_md[k]    <= r_d3[k][DW-1] ? NW'(-NW'(r_d3[k])) : NW'(NW'(r_d3[k]));
                r_mn5[k]    <= r_mn[k];
                r_md5[k]    <= r_md[k];
                r_sgn_n5[k] <= r_sgn_n[k];
                r_sgn_d5[k] <= r_sgn_d[k];
            end
            r_topn <= bitlen(r_mn[0] | r_mn[1] | r_mn[2]);
            r_topd <= bitlen(r_md[0] | r_md[1] | r_md[2]);
            for (int k = 0; k < 3; k++) begin
                r_sn[k] <= r_sgn_n5[k] ? -SW'({1'b0, scale_mag(r_mn5[k], r_topn)})
                                       :  SW'({1'b0, scale_mag(r_mn5[k], r_topn)});
                r_sd[k] <= r_sgn_d5[k] ? -SW'({1'b0, scale_mag(r_md5[k], r_topd)})
                                       :  SW'({1'b0, scale_mag(r_md5[k], r_topd)});
                r_nd[k] <= r_sn[k] * r_sd[k];
                r_nn[k] <= r_sn[k] * r_sn[k];
                r_dd[k] <= r_sd[k] * r_sd[k];
            end
            r_dg6 <= (r_topn == '0) || (r_topd == '0);
            r_dg7 <= r_dg6;
            for (int s = 0; s <= SQ_ST; s++) begin
                r_sq[s] <= n_sq[s];
            end
            r_den <= r_sq[SQ_ST].rootn * r_sq[SQ_ST].rootd;
            r_dot <= r_sq[SQ_ST].dot;
            r_dgd <= r_sq[SQ_ST].degen;
            for (int s = 0; s <= DIV_ST; s++) begin
                r_dv[s] <= n_dv[s];
            end
            r_bright <= n_bright;
            r_degen  <= r_dv[DIV_ST].degen;
        end
    end

    assign o_res.valid      = r_vld[NST-1];
    assign o_res.brightness = r_bright;
    assign o_res.degenerate = r_degen;

endmodule

@@ hw/rtl/tli_chk.sv @@
// Checker for the ports of the triangle Lambert intensity block, and the bind that attaches it.
// It depends on tli_pkg and on the top level's port names.
module tli_chk import tli_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [OUTW-1:0] i_brightness,
    input logic            i_degenerate
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow the output stall");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_brightness == '0)
        else $error("degenerate item with nonzero brightness");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_brightness <= ONE)
        else $error("brightness above one");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item valid right after reset");

endmodule

bind triangle_lambert_intensity tli_chk u_tli_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_tri.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_brightness (o_res.brightness),
    .i_degenerate (o_res.degenerate)
);
